/* src/gfd_pkg.sv */
// Types and constants shared by the grip and fall detector.
`default_nettype none

package gfd_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int HOLD_BITS   = 4;
	localparam int FALL_BITS   = 6;
	localparam int GRIP_BITS   = 5;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 12;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_HOLD_THRESHOLD = 3'd0,
		CFG_FALL_THRESHOLD = 3'd1,
		CFG_HOLD_ON_COUNT  = 3'd2,
		CFG_RELEASE_COUNT  = 3'd3,
		CFG_FALL_LIMIT     = 3'd4
	} cfg_index_t;

	localparam logic [SAMPLE_BITS-1:0] HOLD_THRESHOLD_RST = 12'd1434;
	localparam logic [SAMPLE_BITS-1:0] FALL_THRESHOLD_RST = 12'd2703;
	localparam logic [HOLD_BITS-1:0]   HOLD_ON_COUNT_RST  = 4'd2;
	localparam logic [HOLD_BITS-1:0]   RELEASE_COUNT_RST  = 4'd8;
	localparam logic [FALL_BITS-1:0]   FALL_LIMIT_RST     = 6'd30;

	localparam logic KIND_FLEX  = 1'b0;
	localparam logic KIND_ACCEL = 1'b1;

	typedef enum logic [1:0] {
		MODE_REST    = 2'd0,
		MODE_WALK    = 2'd1,
		MODE_FALLING = 2'd2,
		MODE_FELL    = 2'd3
	} mode_t;

	typedef struct packed {
		logic                   kind;
		logic [SAMPLE_BITS-1:0] sample;
	} in_word_t;

	typedef struct packed {
		mode_t mode;
		logic  held;
		logic  fall_event;
		logic  alarm;
	} out_word_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] hold_threshold;
		logic [SAMPLE_BITS-1:0] fall_threshold;
		logic [HOLD_BITS-1:0]   hold_on_count;
		logic [HOLD_BITS-1:0]   release_count;
		logic [FALL_BITS-1:0]   fall_limit;
	} cfg_t;

	typedef struct packed {
		mode_t                        mode;
		logic                         held;
		logic signed [GRIP_BITS-1:0]  grip;
		logic [FALL_BITS-1:0]         fall_cnt;
		logic                         fell;
	} state_t;

endpackage

`default_nettype wire

/* src/gfd_update.sv */
// Next-state and result logic for one sensor word.
`default_nettype none

module gfd_update import gfd_pkg::*; (
	input  var in_word_t  word,
	input  var cfg_t      cfg,
	input  var state_t    cur,
	output var state_t    nxt,
	output var out_word_t res
);

	logic signed [GRIP_BITS:0] grip_up;
	logic signed [GRIP_BITS:0] grip_dn;
	logic signed [GRIP_BITS:0] on_lim;
	logic signed [GRIP_BITS:0] rel_lim;
	logic [FALL_BITS:0]        fall_up;
	logic                      gripped;
	logic                      falling;
	logic                      event_w;

	assign gripped = word.sample > cfg.hold_threshold;
	assign falling = word.sample >= cfg.fall_threshold;
	assign grip_up = {cur.grip[GRIP_BITS-1], cur.grip} + (GRIP_BITS+1)'(1);
	assign grip_dn = {cur.grip[GRIP_BITS-1], cur.grip} - (GRIP_BITS+1)'(1);
	assign on_lim  = $signed({(GRIP_BITS+1-HOLD_BITS)'(0), cfg.hold_on_count});
	assign rel_lim = -$signed({(GRIP_BITS+1-HOLD_BITS)'(0), cfg.release_count});
	assign fall_up = {1'b0, cur.fall_cnt} + (FALL_BITS+1)'(1);

	always_comb begin
		nxt     = cur;
		event_w = 1'b0;
		if (word.kind == KIND_FLEX) begin
			if (cur.mode == MODE_REST || cur.mode == MODE_WALK) begin
				if (!cur.held) begin
					if (gripped) begin
						if (grip_up >= on_lim) begin
							nxt.held = 1'b1;
							nxt.grip = '0;
							nxt.mode = MODE_WALK;
						end else begin
							nxt.grip = grip_up[GRIP_BITS-1:0];
						end
					end else if (cur.grip > 0) begin
						nxt.grip = grip_dn[GRIP_BITS-1:0];
					end
				end else begin
					if (!gripped) begin
						if (grip_dn <= rel_lim) begin
							nxt.held = 1'b0;
							nxt.grip = '0;
							nxt.mode = MODE_REST;
						end else begin
							nxt.grip = grip_dn[GRIP_BITS-1:0];
						end
					end else begin
						nxt.grip = '0;
					end
				end
			end
		end else if (cur.held && !cur.fell) begin
			if (falling) begin
				if (fall_up >= {1'b0, cfg.fall_limit}) begin
					nxt.mode     = MODE_FELL;
					nxt.fell     = 1'b1;
					nxt.fall_cnt = '0;
					event_w      = 1'b1;
				end else begin
					nxt.mode     = MODE_FALLING;
					nxt.fall_cnt = fall_up[FALL_BITS-1:0];
				end
			end else if (cur.fall_cnt != '0) begin
				nxt.mode     = MODE_WALK;
				nxt.fall_cnt = cur.fall_cnt - FALL_BITS'(1);
			end
		end
	end

	always_comb begin
		res.mode       = nxt.mode;
		res.held       = nxt.held;
		res.fall_event = event_w;
		res.alarm      = nxt.fell;
	end

endmodule

`default_nettype wire

/* src/grip_and_fall_detector.sv */
// Grip qualification and fall detection from flex and accelerometer words.
//
//   channel  direction  handshake              content
//   in       input      in_valid / in_stall    in_word: kind, sample
//   out      output     out_valid / out_stall  out_word: mode, held, fall_event, alarm
//   cfg      input      cfg_wr_en              cfg_index, cfg_data
//
// Result word is registered after its input word is accepted; one word per cycle sustained while out_stall is low.
// The input register feeds the state update, which loads state and result register together.
// in_stall rises only when the input register is full and the result register is held.
// Reset restores register defaults and returns to rest, not held, counters clear, no alarm.
`default_nettype none

module grip_and_fall_detector import gfd_pkg::*; (
	input  var logic                     clk,
	input  var logic                     arst_n,
	input  var logic                     in_valid,
	output var logic                     in_stall,
	input  var in_word_t                 in_word,
	output var logic                     out_valid,
	input  var logic                     out_stall,
	output var out_word_t                out_word,
	input  var logic                     cfg_wr_en,
	input  var logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  var logic [CFG_DATA_BITS-1:0] cfg_data
);

	cfg_t      cfg_q;
	state_t    state_q;
	state_t    state_nxt;
	out_word_t res;
	logic      valid_s1;
	in_word_t  word_s1;
	logic      out_valid_q;
	out_word_t out_word_q;
	logic      advance;

	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_threshold <= HOLD_THRESHOLD_RST;
			cfg_q.fall_threshold <= FALL_THRESHOLD_RST;
			cfg_q.hold_on_count  <= HOLD_ON_COUNT_RST;
			cfg_q.release_count  <= RELEASE_COUNT_RST;
			cfg_q.fall_limit     <= FALL_LIMIT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_HOLD_THRESHOLD: cfg_q.hold_threshold <= cfg_data[SAMPLE_BITS-1:0];
				CFG_FALL_THRESHOLD: cfg_q.fall_threshold <= cfg_data[SAMPLE_BITS-1:0];
				CFG_HOLD_ON_COUNT:  cfg_q.hold_on_count  <= cfg_data[HOLD_BITS-1:0];
				CFG_RELEASE_COUNT:  cfg_q.release_count  <= cfg_data[HOLD_BITS-1:0];
				CFG_FALL_LIMIT:     cfg_q.fall_limit     <= cfg_data[FALL_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			word_s1 <= in_word;
		end
	end

	gfd_update u_update (
		.word (word_s1),
		.cfg  (cfg_q),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_word_q <= res;
		end
	end

`ifndef NO_ASSERTIONS
	a_fell_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.fell |=> state_q.fell)
		else $error("latched fall cleared");

	a_event_alarm: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.fall_event |-> out_word.alarm && out_word.mode == MODE_FELL)
		else $error("fall event without alarm in fell mode");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled with room downstream");

	a_grip_sign: assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.held |-> state_q.grip >= 0)
		else $error("negative grip count while not held");

	a_fall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.fall_cnt != '0 |-> !state_q.fell)
		else $error("fall count left after a latched fall");
`endif

endmodule

`default_nettype wire
